### rtl/core/tccb_pkg.sv
// Shared types and constants for the text console cell buffer.
// No dependencies; used by tccb_cell_ram and the top level in rtl/core.
package tccb_pkg;

   localparam int CELL_W = 16;

   localparam logic OP_PRINT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   localparam logic REG_COLUMNS = 1'b0;
   localparam logic REG_ROWS    = 1'b1;

   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd25;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PRINT,
      ST_WRITE,
      ST_LIMIT,
      ST_PRIME,
      ST_SCROLL
   } state_type;

endpackage

### rtl/core/tccb_cell_ram.sv
// Cell store: one write port and one read port with registered read data.
// Depends on tccb_pkg for the cell width.
module tccb_cell_ram #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [tccb_pkg::CELL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [tccb_pkg::CELL_W-1:0] rd_data
);

   logic [tccb_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tccb_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tccb_mul_unit.sv
// Shared multiplier with a registered product, used for row base addresses.
// Depends on tccb_pkg only through the caller; holds its product when idle.
module tccb_mul_unit #(
   parameter int A_W = 7,
   parameter int B_W = 8
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [A_W-1:0]     op_a,
   input  logic [B_W-1:0]     op_b,
   output logic [A_W+B_W-1:0] product
);

   logic [A_W+B_W-1:0] product_ff;
   logic [A_W+B_W-1:0] product_in;

   always_comb begin
      product_in = product_ff;
      if (enable) begin
         product_in = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### rtl/core/text_console_cell_buffer.sv
// Top level of the text console cell buffer: sequencer, cursor and registers.
// Depends on tccb_pkg, tccb_cell_ram and tccb_mul_unit.
//
// An item is taken when start is high and busy is low. A print item writes
// colour and character at the cursor and moves the cursor, unless the row is
// full; a newline moves to the next row and scrolls when the bottom is passed.
// A read item fetches one cell. Every item gives one result, shown for exactly
// one cycle with rsp_valid high; the receiver cannot stall it.
// A read passes ST_READ; a print passes ST_PRINT, ST_WRITE (skipped for a
// newline or a full row) and ST_LIMIT. A scroll adds ST_PRIME and ST_SCROLL,
// moving one cell per cycle through the cell store's single write port.
// The next item may be taken in the cycle its predecessor's result is shown.
// After reset the store is cleared one cell per cycle, all MAX_COLS*MAX_ROWS
// cells, with busy high; configuration writes are taken meanwhile.
// The APB port holds columns at address 0 and rows at address 4.
module text_console_cell_buffer #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_colour,
   input  logic [12:0] req_cell_index,
   output logic        rsp_valid,
   output logic [7:0]  rsp_cursor_col,
   output logic [5:0]  rsp_cursor_row,
   output logic        rsp_scrolled,
   output logic [15:0] rsp_cell_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int LINE_W = $clog2(MAX_ROWS + 1);
   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int PROD_W = LINE_W + COL_W;
   localparam int CW     = tccb_pkg::CELL_W;

   tccb_pkg::state_type state_ff, state_in;

   logic [7:0]        columns_ff, columns_in;
   logic [6:0]        rows_ff, rows_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [CNT_W-1:0]  dst_ff, dst_in;
   logic              scroll_ff, scroll_in;
   logic [7:0]        char_ff, char_in;
   logic [7:0]        colour_ff, colour_in;
   logic              in_range_ff, in_range_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_col_ff, rsp_col_in;
   logic [5:0]        rsp_row_ff, rsp_row_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;
   logic [CW-1:0]     rsp_value_ff, rsp_value_in;

   logic [COL_W-1:0]  w_eff;
   logic [LINE_W-1:0] h_eff;
   logic [8:0]        cols_wide;
   logic [7:0]        rows_wide;

   logic              accept;
   logic              csr_write;
   logic              finish;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CW-1:0]     mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [CW-1:0]     mem_rdata;
   logic              mul_en;
   logic [LINE_W-1:0] mul_a;
   logic [COL_W-1:0]  mul_b;
   logic [PROD_W-1:0] mul_p;

   logic [CNT_W-1:0]  w_cnt;
   logic [CNT_W-1:0]  prod_cnt;
   logic [CNT_W-1:0]  print_addr;
   logic [CNT_W-1:0]  scroll_src;
   logic [CNT_W-1:0]  scroll_end;
   logic [ADDR_W+12:0] idx_ext;
   logic [COL_W+7:0]  col_ext;
   logic [LINE_W+5:0] line_ext;
   logic              is_newline;
   logic              need_scroll;

   assign cols_wide = {1'b0, columns_ff};
   assign rows_wide = {1'b0, rows_ff};

   always_comb begin
      if (columns_ff == 8'd0) begin
         w_eff = COL_W'(1);
      end else if (cols_wide > 9'(MAX_COLS)) begin
         w_eff = COL_W'(MAX_COLS);
      end else begin
         w_eff = COL_W'(cols_wide);
      end
      if (rows_ff == 7'd0) begin
         h_eff = LINE_W'(1);
      end else if (rows_wide > 8'(MAX_ROWS)) begin
         h_eff = LINE_W'(MAX_ROWS);
      end else begin
         h_eff = LINE_W'(rows_wide);
      end
   end

   assign busy        = (state_ff != tccb_pkg::ST_IDLE);
   assign accept      = start && !busy;
   assign csr_write   = psel && penable && pwrite && pready;
   assign pready      = 1'b1;
   assign prdata      = (paddr[2] == tccb_pkg::REG_ROWS) ? 32'(rows_ff) : 32'(columns_ff);

   assign w_cnt       = CNT_W'(w_eff);
   assign prod_cnt    = CNT_W'(mul_p);
   assign print_addr  = prod_cnt + CNT_W'(col_ff);
   assign scroll_src  = dst_ff + w_cnt + CNT_W'(1);
   assign scroll_end  = prod_cnt + w_cnt - CNT_W'(1);
   assign idx_ext     = (ADDR_W+13)'(req_cell_index);
   assign col_ext     = (COL_W+8)'(col_ff);
   assign line_ext    = (LINE_W+6)'(line_ff);
   assign is_newline  = (char_ff == tccb_pkg::CHAR_NEWLINE);
   assign need_scroll = (line_ff >= h_eff);

   tccb_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   tccb_mul_unit #(
      .A_W (LINE_W),
      .B_W (COL_W)
   ) u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccb_pkg::ST_CLEAR: begin
            if (dst_ff == CNT_W'(CELLS - 1)) begin
               state_in = tccb_pkg::ST_IDLE;
            end
         end
         tccb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_operation == tccb_pkg::OP_READ) ?
                          tccb_pkg::ST_READ : tccb_pkg::ST_PRINT;
            end
         end
         tccb_pkg::ST_READ: begin
            state_in = tccb_pkg::ST_IDLE;
         end
         tccb_pkg::ST_PRINT: begin
            if (!is_newline && (col_ff < w_eff)) begin
               state_in = tccb_pkg::ST_WRITE;
            end else begin
               state_in = tccb_pkg::ST_LIMIT;
            end
         end
         tccb_pkg::ST_WRITE: begin
            state_in = tccb_pkg::ST_LIMIT;
         end
         tccb_pkg::ST_LIMIT: begin
            state_in = need_scroll ? tccb_pkg::ST_PRIME : tccb_pkg::ST_IDLE;
         end
         tccb_pkg::ST_PRIME: begin
            state_in = tccb_pkg::ST_SCROLL;
         end
         tccb_pkg::ST_SCROLL: begin
            if (dst_ff == scroll_end) begin
               state_in = tccb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccb_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath controls and register updates.
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = dst_ff[ADDR_W-1:0];
      mem_wdata   = '0;
      mem_raddr   = scroll_src[ADDR_W-1:0];
      mul_en      = 1'b0;
      mul_a       = line_ff;
      mul_b       = w_eff;
      finish      = 1'b0;
      col_in      = col_ff;
      line_in     = line_ff;
      dst_in      = dst_ff;
      scroll_in   = scroll_ff;
      char_in     = char_ff;
      colour_in   = colour_ff;
      in_range_in = in_range_ff;
      unique case (state_ff)
         tccb_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            dst_in = dst_ff + CNT_W'(1);
         end
         tccb_pkg::ST_IDLE: begin
            mem_raddr = idx_ext[ADDR_W-1:0];
            if (accept) begin
               char_in     = req_char_code;
               colour_in   = req_colour;
               in_range_in = (32'(req_cell_index) < 32'(CELLS));
               scroll_in   = 1'b0;
            end
         end
         tccb_pkg::ST_READ: begin
            finish = 1'b1;
         end
         tccb_pkg::ST_PRINT: begin
            mul_en = 1'b1;
            if (is_newline) begin
               line_in = line_ff + LINE_W'(1);
               col_in  = '0;
            end
         end
         tccb_pkg::ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = print_addr[ADDR_W-1:0];
            mem_wdata = {colour_ff, char_ff};
            col_in    = col_ff + COL_W'(1);
         end
         tccb_pkg::ST_LIMIT: begin
            mul_a  = h_eff - LINE_W'(1);
            dst_in = '0;
            if (need_scroll) begin
               mul_en    = 1'b1;
               line_in   = h_eff - LINE_W'(1);
               scroll_in = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         tccb_pkg::ST_PRIME: begin
            mem_raddr = w_cnt[ADDR_W-1:0];
         end
         tccb_pkg::ST_SCROLL: begin
            mem_we    = 1'b1;
            mem_wdata = (dst_ff < prod_cnt) ? mem_rdata : '0;
            dst_in    = dst_ff + CNT_W'(1);
            if (dst_ff == scroll_end) begin
               finish = 1'b1;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_write) begin
         if (paddr[2] == tccb_pkg::REG_ROWS) begin
            rows_in = pwdata[6:0];
         end else begin
            columns_in = pwdata[7:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in    = finish;
      rsp_col_in      = col_ext[7:0];
      rsp_row_in      = line_ext[5:0];
      rsp_scrolled_in = scroll_ff;
      rsp_value_in    = '0;
      if (state_ff == tccb_pkg::ST_READ) begin
         rsp_scrolled_in = 1'b0;
         rsp_value_in    = in_range_ff ? mem_rdata : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccb_pkg::ST_CLEAR;
         columns_ff   <= tccb_pkg::COLUMNS_RESET;
         rows_ff      <= tccb_pkg::ROWS_RESET;
         col_ff       <= '0;
         line_ff      <= '0;
         dst_ff       <= '0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         dst_ff       <= dst_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff         <= char_in;
      colour_ff       <= colour_in;
      in_range_ff     <= in_range_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_value_ff    <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_cell_value = rsp_value_ff;

   // Every item returns to ST_IDLE after its result, so results never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   // The cursor column never passes the largest row width.
   assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(MAX_COLS))
      else $error("cursor column beyond row width");

   // Between items the cursor row always lies inside the store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tccb_pkg::ST_IDLE) |-> (line_ff < LINE_W'(MAX_ROWS)))
      else $error("cursor row outside the store");

   // A scroll only happens on a print, which reports no cell value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cell_value == '0))
      else $error("scrolled result carries a cell value");

endmodule
